FILE: design/avt_pkg.sv
// ----------------------------------------------------------------------------
// avt_pkg: shared types and constants for the affine vertex transform
// Word layouts, mode and register codes, and lane operand types.
// ----------------------------------------------------------------------------
package avt_pkg;

	localparam int COORD_W = 32;
	localparam int COEF_W  = 33;
	localparam int PROD_W  = COORD_W + COEF_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int FRAC_W  = 16;
	localparam int TRIG_W  = 18;
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 3;

	// mode codes
	localparam logic [MODE_W-1:0] MODE_TRANSLATE = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SCALE     = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT_XY    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT_ZY    = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ROT_XZ    = 3'd4;

	// register indexes
	localparam logic [INDEX_W-1:0] REG_MODE    = 3'd0;
	localparam logic [INDEX_W-1:0] REG_PARAM_X = 3'd1;
	localparam logic [INDEX_W-1:0] REG_PARAM_Y = 3'd2;
	localparam logic [INDEX_W-1:0] REG_PARAM_Z = 3'd3;
	localparam logic [INDEX_W-1:0] REG_COS     = 3'd4;
	localparam logic [INDEX_W-1:0] REG_SIN     = 3'd5;

	// 1.0 in Q16.16
	localparam logic signed [COEF_W-1:0] ONE_COEF   = 33'sd65536;
	localparam logic signed [TRIG_W-1:0] ONE_TRIG   = 18'sd65536;
	localparam logic signed [SUM_W-1:0]  ROUND_HALF = 66'sd32768;
	localparam logic signed [COORD_W-1:0] SAT_MAX   = 32'sh7fff_ffff;
	localparam logic signed [COORD_W-1:0] SAT_MIN   = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_in;
		logic signed [COORD_W-1:0] y_in;
		logic signed [COORD_W-1:0] z_in;
		logic                      last_in;
	} vtx_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_out;
		logic signed [COORD_W-1:0] y_out;
		logic signed [COORD_W-1:0] z_out;
		logic                      last_out;
	} vtx_out_t;

	// one lane computes round(a0*m0 + a1*m1)
	typedef struct packed {
		logic signed [COORD_W-1:0] a0;
		logic signed [COEF_W-1:0]  m0;
		logic signed [COORD_W-1:0] a1;
		logic signed [COEF_W-1:0]  m1;
	} avt_ops_t;

	// stage load enables shared by all lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} avt_pipe_ctl_t;

endpackage

FILE: design/avt_lane.sv
// ----------------------------------------------------------------------------
// avt_lane: one coordinate lane of the transform pipeline
// Register operands, multiply, sum with rounding half, then floor and saturate.
// ----------------------------------------------------------------------------
module avt_lane (
	input  logic                   clk,
	input  avt_pkg::avt_pipe_ctl_t ctl,
	input  avt_pkg::avt_ops_t      ops,
	output logic signed [31:0]     result
);
	import avt_pkg::*;

	avt_ops_t                  ops_s1;
	logic signed [PROD_W-1:0]  p0_s2;
	logic signed [PROD_W-1:0]  p1_s2;
	logic signed [SUM_W-1:0]   sum_s3;
	logic signed [COORD_W-1:0] res_s4;
	logic signed [COORD_W-1:0] sat_val;
	logic [SUM_W-1:COORD_W+FRAC_W-1] top_bits;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			ops_s1 <= ops;
		end
		if (ctl.en_s2) begin
			p0_s2 <= ops_s1.a0 * ops_s1.m0;
			p1_s2 <= ops_s1.a1 * ops_s1.m1;
		end
		if (ctl.en_s3) begin
			sum_s3 <= p0_s2 + p1_s2 + ROUND_HALF;
		end
		if (ctl.en_s4) begin
			res_s4 <= sat_val;
		end
	end

	// floor by dropping fraction bits; fits when the upper bits are all sign
	assign top_bits = sum_s3[SUM_W-1:COORD_W+FRAC_W-1];

	always_comb begin
		if ((&top_bits) || !(|top_bits)) begin
			sat_val = sum_s3[COORD_W+FRAC_W-1:FRAC_W];
		end else if (sum_s3[SUM_W-1]) begin
			sat_val = SAT_MIN;
		end else begin
			sat_val = SAT_MAX;
		end
	end

	assign result = res_s4;

endmodule

FILE: design/affine_vertex_transform.sv
// ----------------------------------------------------------------------------
// affine_vertex_transform: per-vertex 3D affine transform, signed Q16.16
// Translate, scale or rotate one coordinate pair, rounded and saturated.
// ----------------------------------------------------------------------------
// Pipeline: four register stages (operand select, multiply, sum and round,
//   saturate); the wide multiply and sum each get a stage of their own,
//   which sets the depth.
// Throughput: one vertex per cycle; a stall backs up stage by stage.
// Reset: arst_n clears all stage valid bits and loads mode translate,
//   offsets zero, cos 1.0 and sin zero; data registers are not reset.
module affine_vertex_transform (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  avt_pkg::vtx_in_t    in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output avt_pkg::vtx_out_t   out_data,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [31:0]         wr_data
);
	import avt_pkg::*;

	// configuration registers
	logic [MODE_W-1:0]         mode_q;
	logic signed [COORD_W-1:0] param_x_q;
	logic signed [COORD_W-1:0] param_y_q;
	logic signed [COORD_W-1:0] param_z_q;
	logic signed [TRIG_W-1:0]  cos_q;
	logic signed [TRIG_W-1:0]  sin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_TRANSLATE;
			param_x_q <= '0;
			param_y_q <= '0;
			param_z_q <= '0;
			cos_q     <= ONE_TRIG;
			sin_q     <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MODE:    mode_q    <= wr_data[MODE_W-1:0];
				REG_PARAM_X: param_x_q <= wr_data;
				REG_PARAM_Y: param_y_q <= wr_data;
				REG_PARAM_Z: param_z_q <= wr_data;
				REG_COS:     cos_q     <= wr_data[TRIG_W-1:0];
				REG_SIN:     sin_q     <= wr_data[TRIG_W-1:0];
				default:     ;  // drop writes to unknown indexes
			endcase
		end
	end

	// pipeline control: a stage loads when it is empty or the next one loads
	logic          v_s1, v_s2, v_s3, v_s4;
	logic          last_s1, last_s2, last_s3, last_s4;
	avt_pipe_ctl_t ctl;

	assign ctl.en_s4 = !v_s4 || out_ready;
	assign ctl.en_s3 = !v_s3 || ctl.en_s4;
	assign ctl.en_s2 = !v_s2 || ctl.en_s3;
	assign ctl.en_s1 = !v_s1 || ctl.en_s2;
	assign in_ready  = ctl.en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1 <= in_valid;
			if (ctl.en_s2) v_s2 <= v_s1;
			if (ctl.en_s3) v_s3 <= v_s2;
			if (ctl.en_s4) v_s4 <= v_s3;
		end
	end

	// last flag rides alongside the lanes
	always_ff @(posedge clk) begin
		if (ctl.en_s1) last_s1 <= in_data.last_in;
		if (ctl.en_s2) last_s2 <= last_s1;
		if (ctl.en_s3) last_s3 <= last_s2;
		if (ctl.en_s4) last_s4 <= last_s3;
	end

	// operand select: every mode maps onto round(a0*m0 + a1*m1) per lane.
	// Translate multiplies both coordinate and offset by 1.0 so the rounding
	// path gives the exact sum; pass-through multiplies by 1.0 alone.
	logic signed [COEF_W-1:0] cos_ext, sin_ext, nsin_ext;
	logic signed [COEF_W-1:0] px_ext, py_ext, pz_ext;
	avt_ops_t ops_x, ops_y, ops_z, pass_x, pass_y, pass_z;

	assign cos_ext  = {{(COEF_W-TRIG_W){cos_q[TRIG_W-1]}}, cos_q};
	assign sin_ext  = {{(COEF_W-TRIG_W){sin_q[TRIG_W-1]}}, sin_q};
	assign nsin_ext = -sin_ext;
	assign px_ext   = {param_x_q[COORD_W-1], param_x_q};
	assign py_ext   = {param_y_q[COORD_W-1], param_y_q};
	assign pz_ext   = {param_z_q[COORD_W-1], param_z_q};

	assign pass_x = '{a0: in_data.x_in, m0: ONE_COEF, a1: '0, m1: '0};
	assign pass_y = '{a0: in_data.y_in, m0: ONE_COEF, a1: '0, m1: '0};
	assign pass_z = '{a0: in_data.z_in, m0: ONE_COEF, a1: '0, m1: '0};

	always_comb begin
		ops_x = pass_x;
		ops_y = pass_y;
		ops_z = pass_z;
		unique case (mode_q)
			MODE_TRANSLATE: begin
				ops_x = '{a0: in_data.x_in, m0: ONE_COEF, a1: param_x_q, m1: ONE_COEF};
				ops_y = '{a0: in_data.y_in, m0: ONE_COEF, a1: param_y_q, m1: ONE_COEF};
				ops_z = '{a0: in_data.z_in, m0: ONE_COEF, a1: param_z_q, m1: ONE_COEF};
			end
			MODE_SCALE: begin
				ops_x = '{a0: in_data.x_in, m0: px_ext, a1: '0, m1: '0};
				ops_y = '{a0: in_data.y_in, m0: py_ext, a1: '0, m1: '0};
				ops_z = '{a0: in_data.z_in, m0: pz_ext, a1: '0, m1: '0};
			end
			MODE_ROT_XY: begin
				ops_x = '{a0: in_data.x_in, m0: cos_ext, a1: in_data.y_in, m1: sin_ext};
				ops_y = '{a0: in_data.y_in, m0: cos_ext, a1: in_data.x_in, m1: nsin_ext};
			end
			MODE_ROT_ZY: begin
				ops_z = '{a0: in_data.z_in, m0: cos_ext, a1: in_data.y_in, m1: sin_ext};
				ops_y = '{a0: in_data.y_in, m0: cos_ext, a1: in_data.z_in, m1: nsin_ext};
			end
			MODE_ROT_XZ: begin
				ops_x = '{a0: in_data.x_in, m0: cos_ext, a1: in_data.z_in, m1: sin_ext};
				ops_z = '{a0: in_data.z_in, m0: cos_ext, a1: in_data.x_in, m1: nsin_ext};
			end
			default: ;  // undefined modes pass the vertex through
		endcase
	end

	logic signed [COORD_W-1:0] x_res, y_res, z_res;

	avt_lane u_lane_x (.clk(clk), .ctl(ctl), .ops(ops_x), .result(x_res));
	avt_lane u_lane_y (.clk(clk), .ctl(ctl), .ops(ops_y), .result(y_res));
	avt_lane u_lane_z (.clk(clk), .ctl(ctl), .ops(ops_z), .result(z_res));

	// stage 4 is the output register for the word
	assign out_valid         = v_s4;
	assign out_data.x_out    = x_res;
	assign out_data.y_out    = y_res;
	assign out_data.z_out    = z_res;
	assign out_data.last_out = last_s4;

endmodule

FILE: design/avt_checker.sv
// ----------------------------------------------------------------------------
// avt_checker: port-level checks for the affine vertex transform
// Output hold under stall, free input when empty, and pipeline latency.
// ----------------------------------------------------------------------------
module avt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input avt_pkg::vtx_out_t out_data
);
	import avt_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed under stall");

	// with nothing at the output the whole pipe can move
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");

	// an accepted word reaches the output while the output stays ready
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("word did not reach output in four cycles");

endmodule

bind affine_vertex_transform avt_checker u_avt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);
